// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the top rtl file of the handshake engine
// depends on nothing; the including module provides aclk and aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ghe_pkg.sv =====
// shared types and constants of the gpib handshake engine
// used by every module of the block; depends on nothing
package ghe_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_ABORT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RD_LOW  = 3'd1,
        PH_RD_HIGH = 3'd2,
        PH_WR_NRFD = 3'd3,
        PH_WR_NDAC = 3'd4,
        PH_DONE    = 3'd5,
        PH_TIMO    = 3'd6
    } phase_t;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_TIMO  = 2'd3;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOS_CHAR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOS_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EOS_8BIT   = 2'd2;

    localparam logic [7:0]  SEVEN_BIT_MASK = 8'h7f;
    localparam logic [7:0]  DIO_RELEASED   = 8'hff;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;

    typedef struct packed {
        logic [7:0] eos_char;
        logic       eos_enable;
        logic       eos_8bit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] length;
        logic [7:0]  tx_byte;
        logic        eoi_with_byte;
        logic        as_command;
        logic        line_dav;
        logic        line_nrfd;
        logic        line_ndac;
        logic        line_eoi;
        logic        line_srq;
        logic [7:0]  data_lines;
        logic        timed_out;
    } item_t;

    typedef struct packed {
        logic        drive_dav_low;
        logic        drive_nrfd_low;
        logic        drive_ndac_low;
        logic        drive_eoi_low;
        logic        drive_atn_low;
        logic [7:0]  data_out;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic [15:0] byte_count;
        logic        eoi_seen;
        logic [1:0]  status;
        logic        srq_pending;
    } result_t;

endpackage

// ===== hw/rtl/ghe_in_stage.sv =====
// input register of the handshake engine: holds one item until the core takes it
// depends on ghe_pkg
module ghe_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ghe_pkg::item_t s_item,
    input  logic           down_ready,
    output logic           item_valid,
    output ghe_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    ghe_pkg::item_t item_reg;
    logic           advance;

    assign advance    = valid_reg && down_ready;
    assign s_ready    = !valid_reg || down_ready;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/ghe_core.sv =====
// handshake state machine: phase, counters and held byte, plus result decode
// depends on ghe_pkg
module ghe_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  ghe_pkg::item_t   item,
    input  ghe_pkg::cfg_t    cfg,
    output ghe_pkg::result_t result
);

    ghe_pkg::phase_t phase_reg,       phase_next;
    logic [15:0]     rx_count_reg,    rx_count_next;
    logic [15:0]     request_len_reg, request_len_next;
    logic [7:0]      held_byte_reg,   held_byte_next;
    logic            hold_eoi_reg,    hold_eoi_next;
    logic            hold_atn_reg,    hold_atn_next;
    logic            end_flag_reg,    end_flag_next;

    logic       busy;
    logic       rx_valid;
    logic [7:0] cap_byte;
    logic [15:0] cap_count;
    logic       eos_hit;

    assign busy = (phase_reg == ghe_pkg::PH_RD_LOW) || (phase_reg == ghe_pkg::PH_RD_HIGH) ||
                  (phase_reg == ghe_pkg::PH_WR_NRFD) || (phase_reg == ghe_pkg::PH_WR_NDAC);

    assign cap_byte  = ~item.data_lines;
    assign cap_count = (rx_count_reg < ghe_pkg::COUNT_MAX) ? rx_count_reg + 16'd1
                                                          : rx_count_reg;
    assign eos_hit   = cfg.eos_enable &&
                       (cfg.eos_8bit ? (cap_byte == cfg.eos_char)
                                     : ((cap_byte & ghe_pkg::SEVEN_BIT_MASK) ==
                                        (cfg.eos_char & ghe_pkg::SEVEN_BIT_MASK)));

    always_comb begin
        phase_next       = phase_reg;
        rx_count_next    = rx_count_reg;
        request_len_next = request_len_reg;
        held_byte_next   = held_byte_reg;
        hold_eoi_next    = hold_eoi_reg;
        hold_atn_next    = hold_atn_reg;
        end_flag_next    = end_flag_reg;
        rx_valid         = 1'b0;
        unique case (item.cmd)
            ghe_pkg::CMD_ABORT: begin
                phase_next    = ghe_pkg::PH_IDLE;
                hold_eoi_next = 1'b0;
                hold_atn_next = 1'b0;
            end
            ghe_pkg::CMD_READ: begin
                if (!busy) begin
                    end_flag_next    = 1'b0;
                    rx_count_next    = '0;
                    request_len_next = item.length;
                    phase_next       = (item.length == '0) ? ghe_pkg::PH_DONE
                                                           : ghe_pkg::PH_RD_LOW;
                end
            end
            ghe_pkg::CMD_SEND: begin
                if (!busy) begin
                    end_flag_next  = 1'b0;
                    rx_count_next  = '0;
                    held_byte_next = item.tx_byte;
                    hold_atn_next  = item.as_command;
                    hold_eoi_next  = item.as_command ? 1'b0 : item.eoi_with_byte;
                    phase_next     = ghe_pkg::PH_WR_NRFD;
                end
            end
            ghe_pkg::CMD_TICK: begin
                if (busy) begin
                    if (item.timed_out) begin
                        phase_next = ghe_pkg::PH_TIMO;
                    end else begin
                        unique case (phase_reg)
                            ghe_pkg::PH_RD_LOW: begin
                                if (!item.line_dav) begin
                                    held_byte_next = cap_byte;
                                    rx_count_next  = cap_count;
                                    end_flag_next  = !item.line_eoi;
                                    rx_valid       = 1'b1;
                                    if ((cap_count >= request_len_reg) || !item.line_eoi ||
                                        eos_hit) begin
                                        phase_next = ghe_pkg::PH_DONE;
                                    end else begin
                                        phase_next = ghe_pkg::PH_RD_HIGH;
                                    end
                                end
                            end
                            ghe_pkg::PH_RD_HIGH: begin
                                if (item.line_dav) begin
                                    phase_next = ghe_pkg::PH_RD_LOW;
                                end
                            end
                            ghe_pkg::PH_WR_NRFD: begin
                                if (item.line_nrfd) begin
                                    phase_next = ghe_pkg::PH_WR_NDAC;
                                end
                            end
                            ghe_pkg::PH_WR_NDAC: begin
                                if (item.line_ndac) begin
                                    rx_count_next = 16'd1;
                                    phase_next    = ghe_pkg::PH_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // line drives follow the phase after this item
    always_comb begin
        result                = '0;
        result.data_out       = ghe_pkg::DIO_RELEASED;
        result.rx_valid       = rx_valid;
        result.rx_byte        = rx_valid ? held_byte_next : 8'd0;
        result.byte_count     = rx_count_next;
        result.eoi_seen       = end_flag_next;
        result.srq_pending    = !item.line_srq;
        unique case (phase_next)
            ghe_pkg::PH_RD_LOW: begin
                result.drive_ndac_low = 1'b1;
                result.status         = ghe_pkg::ST_BUSY;
            end
            ghe_pkg::PH_RD_HIGH: begin
                result.drive_nrfd_low = 1'b1;
                result.status         = ghe_pkg::ST_BUSY;
            end
            ghe_pkg::PH_WR_NRFD: begin
                result.drive_atn_low = hold_atn_next;
                result.status        = ghe_pkg::ST_BUSY;
            end
            ghe_pkg::PH_WR_NDAC: begin
                result.drive_atn_low = hold_atn_next;
                result.drive_dav_low = 1'b1;
                result.drive_eoi_low = hold_eoi_next;
                result.data_out      = ~held_byte_next;
                result.status        = ghe_pkg::ST_BUSY;
            end
            ghe_pkg::PH_DONE: begin
                result.drive_nrfd_low = 1'b1;
                result.status         = ghe_pkg::ST_DONE;
            end
            ghe_pkg::PH_TIMO: begin
                result.drive_nrfd_low = 1'b1;
                result.drive_ndac_low = 1'b1;
                result.status         = ghe_pkg::ST_TIMO;
            end
            default: begin
                result.drive_nrfd_low = 1'b1;
                result.drive_ndac_low = 1'b1;
                result.status         = ghe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ghe_pkg::PH_IDLE;
            rx_count_reg    <= '0;
            request_len_reg <= '0;
            held_byte_reg   <= '0;
            hold_eoi_reg    <= 1'b0;
            hold_atn_reg    <= 1'b0;
            end_flag_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            rx_count_reg    <= rx_count_next;
            request_len_reg <= request_len_next;
            held_byte_reg   <= held_byte_next;
            hold_eoi_reg    <= hold_eoi_next;
            hold_atn_reg    <= hold_atn_next;
            end_flag_reg    <= end_flag_next;
        end
    end

endmodule

// ===== hw/rtl/ghe_out_stage.sv =====
// result register of the handshake engine, loaded from the core
// depends on ghe_pkg
module ghe_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ghe_pkg::result_t result,
    output logic             load_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output ghe_pkg::result_t m_result
);

    logic             valid_reg;
    logic             valid_next;
    ghe_pkg::result_t result_reg;

    assign load_ready = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== hw/rtl/gpib_handshake_engine.sv =====
// Three-wire IEEE-488 handshake engine (DAV/NRFD/NDAC). Every item carries a command
// and the sampled bus lines; each accepted item gives exactly one result item with
// the line drives, the received byte if one was taken, the byte count and status.
// One item is accepted per clock when the result side keeps up; each result passes
// the input register, then the result register, with the single pass of the
// handshake state logic between those two registers. The config port is always
// ready and should only be written while the engine is idle.
// depends on ghe_pkg, ghe_in_stage, ghe_core, ghe_out_stage and assert_macros.svh
`include "assert_macros.svh"

module gpib_handshake_engine (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ghe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,

    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_length,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_eoi_with_byte,
    input  logic        s_as_command,
    input  logic        s_line_dav,
    input  logic        s_line_nrfd,
    input  logic        s_line_ndac,
    input  logic        s_line_eoi,
    input  logic        s_line_srq,
    input  logic [7:0]  s_data_lines,
    input  logic        s_timed_out,

    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_drive_dav_low,
    output logic        m_drive_nrfd_low,
    output logic        m_drive_ndac_low,
    output logic        m_drive_eoi_low,
    output logic        m_drive_atn_low,
    output logic [7:0]  m_data_out,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic [15:0] m_byte_count,
    output logic        m_eoi_seen,
    output logic [1:0]  m_status,
    output logic        m_srq_pending
);

    // config registers: eos character and the two mode bits
    ghe_pkg::cfg_t    cfg_reg;
    ghe_pkg::cfg_t    cfg_next;

    ghe_pkg::item_t   s_item;
    ghe_pkg::item_t   item;
    logic             item_valid;
    logic             out_ready;
    logic             fire;
    ghe_pkg::result_t core_result;
    ghe_pkg::result_t m_result;

    // config writes land directly; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ghe_pkg::CFG_EOS_CHAR:   cfg_next.eos_char   = cfg_data;
                ghe_pkg::CFG_EOS_ENABLE: cfg_next.eos_enable = cfg_data[0];
                ghe_pkg::CFG_EOS_8BIT:   cfg_next.eos_8bit   = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pack the input ports into one item
    always_comb begin
        s_item.cmd           = s_cmd;
        s_item.length        = s_length;
        s_item.tx_byte       = s_tx_byte;
        s_item.eoi_with_byte = s_eoi_with_byte;
        s_item.as_command    = s_as_command;
        s_item.line_dav      = s_line_dav;
        s_item.line_nrfd     = s_line_nrfd;
        s_item.line_ndac     = s_line_ndac;
        s_item.line_eoi      = s_line_eoi;
        s_item.line_srq      = s_line_srq;
        s_item.data_lines    = s_data_lines;
        s_item.timed_out     = s_timed_out;
    end

    // input register; it frees up whenever the result register can load
    ghe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .down_ready (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // the item is processed, and the state advances, in the cycle it moves on
    assign fire = item_valid && out_ready;

    ghe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // result register; loads when empty or while the previous result is taken
    ghe_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result     (core_result),
        .load_ready (out_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_drive_dav_low  = m_result.drive_dav_low;
    assign m_drive_nrfd_low = m_result.drive_nrfd_low;
    assign m_drive_ndac_low = m_result.drive_ndac_low;
    assign m_drive_eoi_low  = m_result.drive_eoi_low;
    assign m_drive_atn_low  = m_result.drive_atn_low;
    assign m_data_out       = m_result.data_out;
    assign m_rx_valid       = m_result.rx_valid;
    assign m_rx_byte        = m_result.rx_byte;
    assign m_byte_count     = m_result.byte_count;
    assign m_eoi_seen       = m_result.eoi_seen;
    assign m_status         = m_result.status;
    assign m_srq_pending    = m_result.srq_pending;

    // dav is only pulled while a send is in progress
    `ASSERT_IMPLIES(a_dav_only_busy, m_valid && m_drive_dav_low,
        m_status == ghe_pkg::ST_BUSY, "dav driven outside a transfer")
    // after taking a byte the acceptor always holds nrfd low
    `ASSERT_IMPLIES(a_rx_holds_nrfd, m_valid && m_rx_valid,
        m_drive_nrfd_low && !m_drive_dav_low, "byte taken without nrfd held")
    // data and eoi are released whenever dav is not driven
    `ASSERT_IMPLIES(a_data_released, m_valid && !m_drive_dav_low,
        m_data_out == ghe_pkg::DIO_RELEASED && !m_drive_eoi_low, "dio or eoi driven without dav")
    // input side only stalls when a full result is held up
    `ASSERT_IMPLIES(a_stall_cause, !s_ready, m_valid && !m_ready && item_valid,
        "input stalled without output backpressure")

endmodule
